// ===== rtl/hhlt_pkg.sv =====
// Shared types, constants and character tables for the HTTP header length tracker.
package hhlt_pkg;

    localparam int INSERT_MAX_DEF   = 48;
    localparam int LENGTH_WIDTH_DEF = 32;

    localparam int INS_LEN_W  = 6;
    localparam int INS_WORDS  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WORD_LAST = 3'd6;

    localparam int NAME_LEN = 15;
    localparam logic [4:0] POS_VALUE  = 5'd15;
    localparam logic [4:0] POS_CLOSED = 5'd16;

    localparam logic [2:0] EMC_BODY = 3'd4;
    localparam logic [2:0] HOLD_MAX = 3'd4;

    localparam logic [7:0] NAME_TEXT [NAME_LEN] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
    };
    localparam logic [7:0] BLANK_TEXT [4] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

    localparam logic [7:0] CHAR_0      = "0";
    localparam logic [7:0] CHAR_9      = "9";
    localparam logic [7:0] CHAR_UC_A   = "A";
    localparam logic [7:0] CHAR_UC_Z   = "Z";
    localparam logic [7:0] CHAR_SP     = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_HOLD,
        CLS_INSERT,
        CLS_RELEASE
    } t_cls;

    typedef enum logic [2:0] {
        OSEL_NONE,
        OSEL_CH_IN,
        OSEL_INS,
        OSEL_REL,
        OSEL_CH_HELD
    } t_out_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_RELEASE,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic     in_acc;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_cls cls;
        logic out_free;
        logic ins_last;
        logic rel_last;
        logic has_hold;
    } t_dp_sts;

endpackage

// ===== rtl/hhlt_cfg_regs.sv =====
// Configuration registers: insert length and insert message bytes, with byte read port.
module hhlt_cfg_regs
    import hhlt_pkg::*;
#(
    parameter int INSERT_MAX = INSERT_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [INS_LEN_W-1:0]  i_rd_idx,
    output logic [7:0]            o_rd_byte,
    output logic [INS_LEN_W-1:0]  o_ilen
);

    logic [INS_LEN_W-1:0] r_ins_len;
    logic [7:0][7:0]      r_ins_words [INS_WORDS];
    logic [2:0]           rd_word;
    logic [CFG_IDX_W-1:0] wr_word;

    assign o_cfg_ready = 1'b1;
    assign wr_word     = i_cfg_index - CFG_IDX_WORD0;
    assign rd_word     = i_rd_idx[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_len <= '0;
            for (int i = 0; i < INS_WORDS; i++) begin
                r_ins_words[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_LEN) begin
                r_ins_len <= i_cfg_data[INS_LEN_W-1:0];
            end else if (i_cfg_index >= CFG_IDX_WORD0 && i_cfg_index <= CFG_IDX_WORD_LAST) begin
                r_ins_words[wr_word] <= i_cfg_data;
            end
        end
    end

    // bytes beyond the stored words read zero
    always_comb begin
        if (rd_word < 3'(INS_WORDS)) begin
            o_rd_byte = r_ins_words[rd_word][i_rd_idx[2:0]];
        end else begin
            o_rd_byte = '0;
        end
    end

    assign o_ilen = (r_ins_len > INS_LEN_W'(INSERT_MAX)) ? INS_LEN_W'(INSERT_MAX) : r_ins_len;

endmodule

// ===== rtl/hhlt_datapath.sv =====
// Datapath: blank-line and name matching, length accumulation, hold/release and output register.
module hhlt_datapath
    import hhlt_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_in_byte,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [INS_LEN_W-1:0] i_ilen,
    input  logic [7:0]           i_ins_byte,
    output logic [INS_LEN_W-1:0] o_ins_idx,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last,
    output logic                 o_message_done
);

    localparam int LW = LENGTH_WIDTH;

    // tracking state
    logic [2:0]    r_emc, n_emc;
    logic [4:0]    r_pos, n_pos;
    logic [LW-1:0] r_len, n_len;
    logic          r_seen, n_seen;
    logic [2:0]    r_hold, n_hold;

    // sequence state for a burst
    logic [7:0]           r_ch;
    logic                 r_done;
    logic [1:0]           r_rel_ptr;
    logic [2:0]           r_rel_left;
    logic [INS_LEN_W-1:0] r_ins_idx;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_done;

    logic          is_body;
    logic [2:0]    emc_adv;
    logic          blank_end;
    logic [7:0]    lc;
    logic          digit;
    logic [3:0]    dval;
    logic [LW-1:0] vbase;
    logic [LW+3:0] acc;
    logic [LW-1:0] len_acc;
    logic [4:0]    pos_t;
    logic [LW-1:0] len_t;
    logic          seen_t;
    logic [LW-1:0] len_dec;
    logic          done_now;
    t_cls          cls;
    logic          out_free;

    always_comb begin
        is_body = (r_emc == EMC_BODY);
        emc_adv = (i_in_byte == BLANK_TEXT[r_emc[1:0]]) ? r_emc + 3'd1 : 3'd0;
        blank_end = (emc_adv == EMC_BODY);

        lc = (i_in_byte >= CHAR_UC_A && i_in_byte <= CHAR_UC_Z) ?
             i_in_byte + CASE_OFFSET : i_in_byte;
        digit = (i_in_byte >= CHAR_0 && i_in_byte <= CHAR_9);
        dval  = 4'(i_in_byte - CHAR_0);

        // value * 10 + digit, saturating at all ones
        vbase   = r_seen ? r_len : '0;
        acc     = {1'b0, vbase, 3'b000} + {3'b000, vbase, 1'b0} + {{LW{1'b0}}, dval};
        len_acc = (acc[LW+3:LW] != 4'd0) ? '1 : acc[LW-1:0];

        pos_t  = r_pos;
        len_t  = r_len;
        seen_t = r_seen;
        if (r_pos == POS_VALUE) begin
            if (digit) begin
                len_t  = len_acc;
                seen_t = 1'b1;
            end else if (i_in_byte != CHAR_SP && i_in_byte != CHAR_TAB) begin
                pos_t = POS_CLOSED;
            end
        end else if (r_pos < POS_VALUE) begin
            if (lc == NAME_TEXT[r_pos[3:0]]) begin
                pos_t = r_pos + 5'd1;
            end else begin
                pos_t = '0;
            end
        end

        len_dec = (r_len != '0) ? r_len - LW'(1) : r_len;

        if (is_body) begin
            done_now = (len_dec == '0);
        end else begin
            done_now = blank_end && (!seen_t || len_t == '0);
        end

        if (is_body) begin
            cls = CLS_PASS;
        end else if (blank_end) begin
            if (i_ilen != '0) begin
                cls = CLS_INSERT;
            end else begin
                cls = (r_hold != 3'd0) ? CLS_RELEASE : CLS_PASS;
            end
        end else if (emc_adv != 3'd0 && i_ilen != '0) begin
            cls = CLS_HOLD;
        end else begin
            cls = (r_hold != 3'd0) ? CLS_RELEASE : CLS_PASS;
        end
    end

    always_comb begin
        n_emc  = r_emc;
        n_pos  = r_pos;
        n_len  = r_len;
        n_seen = r_seen;
        n_hold = r_hold;
        if (i_cmd.in_acc) begin
            if (done_now) begin
                n_emc  = '0;
                n_pos  = '0;
                n_len  = '0;
                n_seen = 1'b0;
                n_hold = '0;
            end else if (is_body) begin
                n_len = len_dec;
            end else begin
                n_emc  = emc_adv;
                n_pos  = pos_t;
                n_len  = len_t;
                n_seen = seen_t;
                if (cls == CLS_HOLD) begin
                    n_hold = (r_hold < HOLD_MAX) ? r_hold + 3'd1 : r_hold;
                end else begin
                    n_hold = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emc  <= '0;
            r_pos  <= '0;
            r_len  <= '0;
            r_seen <= 1'b0;
            r_hold <= '0;
        end else begin
            r_emc  <= n_emc;
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_seen <= n_seen;
            r_hold <= n_hold;
        end
    end

    // held bytes are the newest r_hold bytes of the matched prefix
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_acc) begin
            r_ch       <= i_in_byte;
            r_done     <= done_now;
            r_rel_left <= r_hold;
            r_rel_ptr  <= r_emc[1:0] - r_hold[1:0];
            r_ins_idx  <= '0;
        end else if (i_cmd.out_sel == OSEL_INS) begin
            r_ins_idx <= r_ins_idx + INS_LEN_W'(1);
        end else if (i_cmd.out_sel == OSEL_REL) begin
            r_rel_ptr  <= r_rel_ptr + 2'd1;
            r_rel_left <= r_rel_left - 3'd1;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_sel != OSEL_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.out_sel)
            OSEL_CH_IN: begin
                r_out_byte <= i_in_byte;
                r_out_last <= 1'b1;
                r_out_done <= done_now;
            end
            OSEL_INS: begin
                r_out_byte <= i_ins_byte;
                r_out_last <= 1'b0;
                r_out_done <= 1'b0;
            end
            OSEL_REL: begin
                r_out_byte <= BLANK_TEXT[r_rel_ptr];
                r_out_last <= 1'b0;
                r_out_done <= 1'b0;
            end
            OSEL_CH_HELD: begin
                r_out_byte <= r_ch;
                r_out_last <= 1'b1;
                r_out_done <= r_done;
            end
            default: begin
                r_out_byte <= r_out_byte;
                r_out_last <= r_out_last;
                r_out_done <= r_out_done;
            end
        endcase
    end

    assign o_sts.cls      = cls;
    assign o_sts.out_free = out_free;
    assign o_sts.ins_last = ((r_ins_idx + INS_LEN_W'(1)) == i_ilen);
    assign o_sts.rel_last = (r_rel_left == 3'd1);
    assign o_sts.has_hold = (r_rel_left != 3'd0);

    assign o_ins_idx      = r_ins_idx;
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last         = r_out_last;
    assign o_message_done = r_out_done;

endmodule

// ===== rtl/hhlt_ctrl.sv =====
// Controller: accepts bytes and sequences insert, release and tail words.
module hhlt_ctrl
    import hhlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.in_acc  = 1'b0;
        o_cmd.out_sel = OSEL_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.in_acc = 1'b1;
                    case (i_sts.cls)
                        CLS_PASS:    o_cmd.out_sel = OSEL_CH_IN;
                        CLS_HOLD:    o_cmd.out_sel = OSEL_NONE;
                        CLS_INSERT:  n_state = ST_INSERT;
                        CLS_RELEASE: n_state = ST_RELEASE;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OSEL_INS;
                    if (i_sts.ins_last) begin
                        n_state = i_sts.has_hold ? ST_RELEASE : ST_TAIL;
                    end
                end
            end
            ST_RELEASE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OSEL_REL;
                    if (i_sts.rel_last) begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OSEL_CH_HELD;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/http_header_length_tracker.sv =====
// Top level of the HTTP header length tracker.
//
// Usage: bytes of an HTTP message enter on the in channel (i_in_valid/o_in_ready,
// i_in_byte); result words leave on the out channel (o_out_valid/i_out_ready)
// with o_out_byte, o_last on the final word caused by an input byte, and
// o_message_done on that word when headers plus body are complete.
// Registers are written on the cfg channel (index 0 insert length, 1..6 message
// words); o_cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while headers and body pass and the output
// register is free. A byte that may be part of the blank line is held with
// insertion on and gives no word. The byte that completes the blank line with
// insertion on, or one that releases held bytes, is followed by the insert
// words (on completion), the held bytes and the byte itself, one word a cycle
// through the single output register, before the next byte is taken. A word
// appears in the cycle after it is loaded. Reset clears the match and length
// state and zeroes the registers; no clearing pass. A stalled receiver holds
// the output register; the input is then refused until it can be loaded again.
module http_header_length_tracker
    import hhlt_pkg::*;
#(
    parameter int INSERT_MAX   = INSERT_MAX_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_last,
    output logic                  o_message_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd              w_cmd;
    t_dp_sts              w_sts;
    logic [INS_LEN_W-1:0] w_ilen;
    logic [INS_LEN_W-1:0] w_ins_idx;
    logic [7:0]           w_ins_byte;

    hhlt_cfg_regs #(
        .INSERT_MAX (INSERT_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd_idx    (w_ins_idx),
        .o_rd_byte   (w_ins_byte),
        .o_ilen      (w_ilen)
    );

    hhlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hhlt_datapath #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_ilen         (w_ilen),
        .i_ins_byte     (w_ins_byte),
        .o_ins_idx      (w_ins_idx),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_message_done (o_message_done)
    );

    // a burst of words is never interleaved with a new input byte
    a_no_accept_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("input taken while a burst is pending");

    // once a non-final word is taken, the next word of the burst follows at once
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)
        else $error("burst word missing");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_message_done) |-> o_last)
        else $error("message done on a non-final word");

    // the datapath only takes a byte on an input handshake
    a_cmd_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.in_acc) |-> (i_in_valid && o_in_ready))
        else $error("byte consumed without handshake");

endmodule
